@@ sv/qhd_pkg.sv @@
package qhd_pkg;

    // Field and register widths
    localparam int ORDER_W     = 9;
    localparam int SYMBOL_W    = 8;
    localparam int GRID_W      = 4;
    localparam int CRD_W       = 6;
    localparam int CFG_INDEX_W = 1;

    // Average energy of each constellation in odd-integer units
    localparam longint unsigned ENERGY_4   = 2;
    localparam longint unsigned ENERGY_8   = 6;
    localparam longint unsigned ENERGY_16  = 10;
    localparam longint unsigned ENERGY_32  = 20;
    localparam longint unsigned ENERGY_64  = 42;
    localparam longint unsigned ENERGY_128 = 82;
    localparam longint unsigned ENERGY_256 = 170;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QAM_ORDER   = 1'b0,
        REG_GRAY_ENABLE = 1'b1
    } cfg_reg_t;

    // Supported constellations, plus the code for an unsupported order
    typedef enum logic [2:0] {
        ORD_4,
        ORD_8,
        ORD_16,
        ORD_32,
        ORD_64,
        ORD_128,
        ORD_256,
        ORD_NONE
    } order_sel_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Grid walked for one constellation
    typedef struct packed {
        logic [GRID_W-1:0] outer_last;
        logic [GRID_W-1:0] inner_last;
        logic [1:0]        cut;
        logic              x_outer;
    } grid_t;

    // Control that travels with each point through the search pipeline
    typedef struct packed {
        logic valid;
        logic keep;
        logic last;
    } tag_t;

    function automatic order_sel_t order_sel(input logic [ORDER_W-1:0] m);
        order_sel_t s;
        unique case (m)
            9'd4:    s = ORD_4;
            9'd8:    s = ORD_8;
            9'd16:   s = ORD_16;
            9'd32:   s = ORD_32;
            9'd64:   s = ORD_64;
            9'd128:  s = ORD_128;
            9'd256:  s = ORD_256;
            default: s = ORD_NONE;
        endcase
        return s;
    endfunction

    function automatic grid_t grid_of(input order_sel_t s);
        grid_t g;
        unique case (s)
            ORD_4:   g = '{outer_last: 4'd1,  inner_last: 4'd1,  cut: 2'd0, x_outer: 1'b0};
            ORD_8:   g = '{outer_last: 4'd1,  inner_last: 4'd3,  cut: 2'd0, x_outer: 1'b0};
            ORD_16:  g = '{outer_last: 4'd3,  inner_last: 4'd3,  cut: 2'd0, x_outer: 1'b0};
            ORD_32:  g = '{outer_last: 4'd5,  inner_last: 4'd5,  cut: 2'd1, x_outer: 1'b1};
            ORD_64:  g = '{outer_last: 4'd7,  inner_last: 4'd7,  cut: 2'd0, x_outer: 1'b0};
            ORD_128: g = '{outer_last: 4'd11, inner_last: 4'd11, cut: 2'd2, x_outer: 1'b1};
            ORD_256: g = '{outer_last: 4'd15, inner_last: 4'd15, cut: 2'd0, x_outer: 1'b0};
            default: g = '0;
        endcase
        return g;
    endfunction

    // Floor square root, evaluated at elaboration for the grid steps
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bit_v;
        rem   = v;
        res   = 0;
        bit_v = 64'h4000_0000_0000_0000;
        while (bit_v > rem)
            bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (rem >= res + bit_v) begin
                rem = rem - res - bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Prefix XOR from the top bit down
    function automatic logic [SYMBOL_W-1:0] bin_from_gray(input logic [SYMBOL_W-1:0] v);
        logic [SYMBOL_W-1:0] r;
        r = v;
        r = r ^ (r >> 1);
        r = r ^ (r >> 2);
        r = r ^ (r >> 4);
        return r;
    endfunction

endpackage

@@ sv/qam_hard_demapper.sv @@
// Channel  | Direction | Handshake          | Payload
// s_*      | in        | s_tvalid/s_tready  | s_tdata: i_sample, q_sample
// m_*      | out       | m_tvalid/m_tready  | m_tdata: symbol; m_tuser: order_error
// cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// For each sample the controller walks the full grid
// of the constellation (4, 8, 16, 36, 64, 144 or 256 points) through the point
// table one point per cycle, then drains the table read, square and compare stages;
// the result loads into the output register once the search is done and it is free.
// An unsupported order skips the search and goes straight to the done state.
// rst_n clears all control and sets qam_order to 16, gray_enable to 0.
// A result waits in the output register; the next sample is taken meanwhile.
// A full output register holds the controller until m_tready frees it.
module qam_hard_demapper #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 13,
    parameter int MAX_ORDER    = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [SW-1:0] i_sample, [2*SW-1:SW] q_sample, zero padded to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] symbol
    output logic [qhd_pkg::SYMBOL_W-1:0]         m_tdata,
    // [0] order_error
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qhd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [qhd_pkg::ORDER_W-1:0]          cfg_data
);

    localparam int IDX_W = $clog2(MAX_ORDER);

    logic signed [SAMPLE_WIDTH-1:0]  i_sample;
    logic signed [SAMPLE_WIDTH-1:0]  q_sample;
    logic signed [SAMPLE_WIDTH-1:0]  si;
    logic signed [SAMPLE_WIDTH-1:0]  sq;
    logic signed [FRAC_BITS+1:0]     px;
    logic signed [FRAC_BITS+1:0]     py;
    qhd_pkg::tag_t                   tag_issue;
    qhd_pkg::tag_t                   tag_rom;
    qhd_pkg::order_sel_t             sel;
    logic [qhd_pkg::GRID_W-1:0]      o;
    logic [qhd_pkg::GRID_W-1:0]      n;
    logic                            start;
    logic                            search_done;
    logic                            out_free;
    logic                            res_load;
    logic                            res_error;
    logic                            gray_enable;
    logic [IDX_W-1:0]                win_idx;
    logic [qhd_pkg::SYMBOL_W-1:0]    idx_ext;
    logic [qhd_pkg::SYMBOL_W-1:0]    symbol_c;
    logic                            m_tvalid_reg;
    logic [qhd_pkg::SYMBOL_W-1:0]    m_tdata_reg;
    logic                            m_tuser_reg;

    assign i_sample = s_tdata[SAMPLE_WIDTH-1:0];
    assign q_sample = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    qhd_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_ORDER    (MAX_ORDER)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .i_sample    (i_sample),
        .q_sample    (q_sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .search_done (search_done),
        .out_free    (out_free),
        .start       (start),
        .tag         (tag_issue),
        .sel         (sel),
        .o           (o),
        .n           (n),
        .si          (si),
        .sq          (sq),
        .res_load    (res_load),
        .res_error   (res_error),
        .gray_enable (gray_enable)
    );

    qhd_point_rom #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rom (
        .clk     (clk),
        .rst_n   (rst_n),
        .sel     (sel),
        .o       (o),
        .n       (n),
        .tag_in  (tag_issue),
        .px      (px),
        .py      (py),
        .tag_out (tag_rom)
    );

    qhd_dist_search #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .IDX_W        (IDX_W)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .si       (si),
        .sq       (sq),
        .px       (px),
        .py       (py),
        .tag      (tag_rom),
        .done     (search_done),
        .win_idx  (win_idx)
    );

    // Form the symbol: zero on error, optional Gray decode
    always_comb
    begin
        idx_ext = qhd_pkg::SYMBOL_W'(win_idx);
        if (res_error)
            symbol_c = '0;
        else if (gray_enable)
            symbol_c = qhd_pkg::bin_from_gray(idx_ext);
        else
            symbol_c = idx_ext;
    end

    // Output register: load when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_tdata_reg <= symbol_c;
            m_tuser_reg <= res_error;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

@@ sv/qhd_point_rom.sv @@
module qhd_point_rom #(
    parameter int FRAC_BITS = 13
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  qhd_pkg::order_sel_t       sel,
    input  logic [qhd_pkg::GRID_W-1:0] o,
    input  logic [qhd_pkg::GRID_W-1:0] n,
    input  qhd_pkg::tag_t             tag_in,
    output logic signed [FRAC_BITS+1:0] px,
    output logic signed [FRAC_BITS+1:0] py,
    output qhd_pkg::tag_t             tag_out
);

    localparam int STEP_W  = FRAC_BITS + 1;
    localparam int COORD_W = FRAC_BITS + 2;
    localparam int PROD_W  = STEP_W + qhd_pkg::CRD_W + 1;

    // Grid step per constellation: 2^FRAC_BITS / sqrt(E), rounded
    localparam longint unsigned SCALE = 64'd1 << (2 * FRAC_BITS + 2);
    localparam logic [STEP_W-1:0] STEP_4   =
        STEP_W'((qhd_pkg::isqrt(SCALE / qhd_pkg::ENERGY_4) + 1) >> 1);
    localparam logic [STEP_W-1:0] STEP_8   =
        STEP_W'((qhd_pkg::isqrt(SCALE / qhd_pkg::ENERGY_8) + 1) >> 1);
    localparam logic [STEP_W-1:0] STEP_16  =
        STEP_W'((qhd_pkg::isqrt(SCALE / qhd_pkg::ENERGY_16) + 1) >> 1);
    localparam logic [STEP_W-1:0] STEP_32  =
        STEP_W'((qhd_pkg::isqrt(SCALE / qhd_pkg::ENERGY_32) + 1) >> 1);
    localparam logic [STEP_W-1:0] STEP_64  =
        STEP_W'((qhd_pkg::isqrt(SCALE / qhd_pkg::ENERGY_64) + 1) >> 1);
    localparam logic [STEP_W-1:0] STEP_128 =
        STEP_W'((qhd_pkg::isqrt(SCALE / qhd_pkg::ENERGY_128) + 1) >> 1);
    localparam logic [STEP_W-1:0] STEP_256 =
        STEP_W'((qhd_pkg::isqrt(SCALE / qhd_pkg::ENERGY_256) + 1) >> 1);

    qhd_pkg::grid_t                    grid;
    logic [STEP_W-1:0]                 step;
    logic signed [qhd_pkg::CRD_W-1:0]  co;
    logic signed [qhd_pkg::CRD_W-1:0]  cn;
    logic signed [qhd_pkg::CRD_W-1:0]  cx;
    logic signed [qhd_pkg::CRD_W-1:0]  cy;
    logic signed [PROD_W-1:0]          prod_x;
    logic signed [PROD_W-1:0]          prod_y;
    logic signed [COORD_W-1:0]         px_reg;
    logic signed [COORD_W-1:0]         py_reg;
    qhd_pkg::tag_t                     tag_reg;

    // Select the step of the active constellation
    always_comb
    begin
        unique case (sel)
            qhd_pkg::ORD_4:   step = STEP_4;
            qhd_pkg::ORD_8:   step = STEP_8;
            qhd_pkg::ORD_16:  step = STEP_16;
            qhd_pkg::ORD_32:  step = STEP_32;
            qhd_pkg::ORD_64:  step = STEP_64;
            qhd_pkg::ORD_128: step = STEP_128;
            qhd_pkg::ORD_256: step = STEP_256;
            default:          step = '0;
        endcase
    end

    // Map grid position to odd coordinates, then scale
    always_comb
    begin
        grid   = qhd_pkg::grid_of(sel);
        co     = $signed({1'b0, o, 1'b0}) - $signed({2'b00, grid.outer_last});
        cn     = $signed({1'b0, n, 1'b0}) - $signed({2'b00, grid.inner_last});
        cx     = grid.x_outer ? co : cn;
        cy     = grid.x_outer ? cn : co;
        prod_x = PROD_W'(cx) * PROD_W'($signed({1'b0, step}));
        prod_y = PROD_W'(cy) * PROD_W'($signed({1'b0, step}));
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        px_reg <= prod_x[COORD_W-1:0];
        py_reg <= prod_y[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    assign px      = px_reg;
    assign py      = py_reg;
    assign tag_out = tag_reg;

endmodule

@@ sv/qhd_dist_search.sv @@
module qhd_dist_search #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 13,
    parameter int IDX_W        = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_WIDTH-1:0] si,
    input  logic signed [SAMPLE_WIDTH-1:0] sq,
    input  logic signed [FRAC_BITS+1:0]   px,
    input  logic signed [FRAC_BITS+1:0]   py,
    input  qhd_pkg::tag_t                 tag,
    output logic                          done,
    output logic [IDX_W-1:0]              win_idx
);

    localparam int COORD_W = FRAC_BITS + 2;
    localparam int DX_W    = ((SAMPLE_WIDTH > COORD_W) ? SAMPLE_WIDTH : COORD_W) + 1;
    localparam int SQ_W    = 2 * DX_W;
    localparam int DIST_W  = SQ_W + 1;

    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy;
    logic signed [SQ_W-1:0]  sqx_c;
    logic signed [SQ_W-1:0]  sqy_c;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    qhd_pkg::tag_t           tag_b_reg;
    logic [DIST_W-1:0]       dist_c;
    logic [DIST_W-1:0]       best_dist_reg;
    logic [IDX_W-1:0]        win_idx_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    have_reg;
    logic                    done_reg;
    logic                    take;
    logic                    better;

    // Offset to the point and square each component
    always_comb
    begin
        dx    = DX_W'(si) - DX_W'(px);
        dy    = DX_W'(sq) - DX_W'(py);
        sqx_c = SQ_W'(dx) * SQ_W'(dx);
        sqy_c = SQ_W'(dy) * SQ_W'(dy);
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= sqx_c;
        sqy_reg <= sqy_c;
    end

    // Sum and compare with the running best; first minimum wins
    always_comb
    begin
        dist_c = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        take   = tag_b_reg.valid && tag_b_reg.keep;
        better = take && (!have_reg || (dist_c < best_dist_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_b_reg <= '0;
            have_reg  <= 1'b0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_b_reg <= tag;
            if (start)
            begin
                have_reg <= 1'b0;
                idx_reg  <= '0;
                done_reg <= 1'b0;
            end
            else
            begin
                done_reg <= tag_b_reg.valid && tag_b_reg.last;
                if (better)
                    have_reg <= 1'b1;
                if (take)
                    idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Hold the winner until the next item starts
    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_dist_reg <= dist_c;
            win_idx_reg   <= idx_reg;
        end
    end

    assign done    = done_reg;
    assign win_idx = win_idx_reg;

endmodule

@@ sv/qhd_ctrl.sv @@
module qhd_ctrl #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_ORDER    = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]    q_sample,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qhd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qhd_pkg::ORDER_W-1:0]       cfg_data,
    input  logic                              search_done,
    input  logic                              out_free,
    output logic                              start,
    output qhd_pkg::tag_t                     tag,
    output qhd_pkg::order_sel_t               sel,
    output logic [qhd_pkg::GRID_W-1:0]        o,
    output logic [qhd_pkg::GRID_W-1:0]        n,
    output logic signed [SAMPLE_WIDTH-1:0]    si,
    output logic signed [SAMPLE_WIDTH-1:0]    sq,
    output logic                              res_load,
    output logic                              res_error,
    output logic                              gray_enable
);

    localparam logic [qhd_pkg::ORDER_W:0] MAX_ORDER_V = (qhd_pkg::ORDER_W + 1)'(MAX_ORDER);

    qhd_pkg::state_t                  state_reg;
    qhd_pkg::state_t                  state_next;
    qhd_pkg::order_sel_t              sel_reg;
    qhd_pkg::order_sel_t              sel_c;
    qhd_pkg::grid_t                   grid;
    logic [qhd_pkg::ORDER_W-1:0]      qam_order_reg;
    logic                             gray_reg;
    logic                             err_reg;
    logic [qhd_pkg::GRID_W-1:0]       o_reg;
    logic [qhd_pkg::GRID_W-1:0]       n_reg;
    logic signed [SAMPLE_WIDTH-1:0]   si_reg;
    logic signed [SAMPLE_WIDTH-1:0]   sq_reg;
    logic [qhd_pkg::GRID_W-1:0]       cut_w;
    logic                             o_edge;
    logic                             n_edge;
    logic                             last_pt;
    logic                             issue;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qam_order_reg <= 9'd16;
            gray_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (qhd_pkg::cfg_reg_t'(cfg_index))
                qhd_pkg::REG_QAM_ORDER:   qam_order_reg <= cfg_data;
                qhd_pkg::REG_GRAY_ENABLE: gray_reg      <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // Decode the order, flagging unsupported sizes and sizes above the build limit
    always_comb
    begin
        if ({1'b0, qam_order_reg} > MAX_ORDER_V)
            sel_c = qhd_pkg::ORD_NONE;
        else
            sel_c = qhd_pkg::order_sel(qam_order_reg);
    end

    // Corner test for the cross constellations, and detection of the last grid point
    always_comb
    begin
        grid    = qhd_pkg::grid_of(sel_reg);
        cut_w   = {2'b00, grid.cut};
        o_edge  = (o_reg < cut_w) || (o_reg > (grid.outer_last - cut_w));
        n_edge  = (n_reg < cut_w) || (n_reg > (grid.inner_last - cut_w));
        last_pt = (o_reg == grid.outer_last) && (n_reg == grid.inner_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= qhd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and handshake outputs
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        start      = 1'b0;
        issue      = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            qhd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    start      = 1'b1;
                    state_next = (sel_c == qhd_pkg::ORD_NONE) ? qhd_pkg::ST_DONE
                                                              : qhd_pkg::ST_RUN;
                end
            end
            qhd_pkg::ST_RUN:
            begin
                issue = 1'b1;
                if (last_pt)
                    state_next = qhd_pkg::ST_DRAIN;
            end
            qhd_pkg::ST_DRAIN:
            begin
                if (search_done)
                begin
                    if (out_free)
                    begin
                        res_load   = 1'b1;
                        state_next = qhd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = qhd_pkg::ST_DONE;
                    end
                end
            end
            qhd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = qhd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qhd_pkg::ST_IDLE;
            end
        endcase
    end

    // Grid counters and per-item settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_reg   <= '0;
            n_reg   <= '0;
            sel_reg <= qhd_pkg::ORD_16;
            err_reg <= 1'b0;
        end
        else if (start)
        begin
            o_reg   <= '0;
            n_reg   <= '0;
            sel_reg <= sel_c;
            err_reg <= (sel_c == qhd_pkg::ORD_NONE);
        end
        else if (issue)
        begin
            if (n_reg == grid.inner_last)
            begin
                n_reg <= '0;
                o_reg <= o_reg + qhd_pkg::GRID_W'(1);
            end
            else
            begin
                n_reg <= n_reg + qhd_pkg::GRID_W'(1);
            end
        end
    end

    // Latch the sample for the whole search
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            si_reg <= i_sample;
            sq_reg <= q_sample;
        end
    end

    assign tag.valid   = issue;
    assign tag.keep    = !((grid.cut != 2'd0) && o_edge && n_edge);
    assign tag.last    = last_pt;
    assign sel         = sel_reg;
    assign o           = o_reg;
    assign n           = n_reg;
    assign si          = si_reg;
    assign sq          = sq_reg;
    assign res_error   = err_reg;
    assign gray_enable = gray_reg;

endmodule

@@ tb/qam_hard_demapper_tb.sv @@
module qam_hard_demapper_tb;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 13;
    localparam int ORDER_MAX  = 256;
    localparam int DIR_N      = 24;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 96;
    localparam int CFG_PAUSE  = 8;
    localparam int TAIL_WAIT  = 300;
    localparam int HANG_LIMIT = 4000;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [qhd_pkg::SYMBOL_W-1:0] sym;
        logic                         err;
    } decision_t;

    typedef struct {
        int order;
        bit gray;
        int i_val;
        int q_val;
        bit typed;
        int sym;
        bit err;
    } demap_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [31:0]                      s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [qhd_pkg::SYMBOL_W-1:0]     m_tdata;
    logic [0:0]                       m_tuser;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [qhd_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [qhd_pkg::ORDER_W-1:0]      cfg_data;

    // Shadow copy of the registers
    logic [qhd_pkg::ORDER_W-1:0]      model_order;
    bit                               model_gray;

    decision_t  pending_decisions[$];
    int         fail_count;
    int         hang_cycles;
    int         src_idle;
    int         sink_stall;
    demap_row_t dir_rows [DIR_N];
    int         phase_order [PHASES];
    bit         phase_gray [PHASES];

    qam_hard_demapper #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .FRAC_BITS   (FRAC_W),
        .MAX_ORDER   (ORDER_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Grid shape and energy of a constellation; energy 0 marks an unsupported order
    function automatic void grid_shape(input logic [qhd_pkg::ORDER_W-1:0] order,
                                       output int outer_n, output int inner_n,
                                       output int cut, output bit x_outer,
                                       output longint unsigned energy);
        outer_n = 0;
        inner_n = 0;
        cut     = 0;
        x_outer = 1'b0;
        energy  = 0;
        case (order)
            9'd4:
            begin
                outer_n = 2;  inner_n = 2;  energy = qhd_pkg::ENERGY_4;
            end
            9'd8:
            begin
                outer_n = 2;  inner_n = 4;  energy = qhd_pkg::ENERGY_8;
            end
            9'd16:
            begin
                outer_n = 4;  inner_n = 4;  energy = qhd_pkg::ENERGY_16;
            end
            9'd32:
            begin
                outer_n = 6;  inner_n = 6;  cut = 1; x_outer = 1'b1;
                energy  = qhd_pkg::ENERGY_32;
            end
            9'd64:
            begin
                outer_n = 8;  inner_n = 8;  energy = qhd_pkg::ENERGY_64;
            end
            9'd128:
            begin
                outer_n = 12; inner_n = 12; cut = 2; x_outer = 1'b1;
                energy  = qhd_pkg::ENERGY_128;
            end
            9'd256:
            begin
                outer_n = 16; inner_n = 16; energy = qhd_pkg::ENERGY_256;
            end
            default:
            begin
                energy = 0;
            end
        endcase
        if (order > ORDER_MAX)
            energy = 0;
    endfunction

    // Unit step: 2^FRAC_W / sqrt(energy), rounded
    function automatic longint grid_step(input longint unsigned energy);
        longint unsigned quot;
        longint unsigned root;
        longint unsigned trial;
        quot = (64'd1 << (2 * FRAC_W + 2)) / energy;
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= quot)
                root = trial;
        end
        return longint'((root + 1) >> 1);
    endfunction

    // Exhaustive nearest-point search under the shadow registers
    function automatic decision_t nearest_symbol(input logic signed [SAMPLE_W-1:0] si,
                                                 input logic signed [SAMPLE_W-1:0] sq);
        decision_t                    res;
        int                           outer_n;
        int                           inner_n;
        int                           cut;
        bit                           x_outer;
        longint unsigned              energy;
        longint                       d;
        longint                       dx;
        longint                       dy;
        longint unsigned              pt_dist;
        longint unsigned              best_dist;
        int                           idx;
        int                           win_idx;
        int                           lvl_o;
        int                           lvl_i;
        bit                           cut_o;
        bit                           cut_i;
        logic [qhd_pkg::SYMBOL_W-1:0] pick;
        grid_shape(model_order, outer_n, inner_n, cut, x_outer, energy);
        res.sym = '0;
        res.err = (energy == 0);
        if (energy != 0)
        begin
            d         = grid_step(energy);
            best_dist = '1;
            win_idx   = 0;
            idx       = 0;
            for (int o = 0; o < outer_n; o++)
            begin
                for (int n = 0; n < inner_n; n++)
                begin
                    cut_o = (o < cut) || (o >= outer_n - cut);
                    cut_i = (n < cut) || (n >= inner_n - cut);
                    if (!(cut_o && cut_i))
                    begin
                        lvl_o = 2 * o - (outer_n - 1);
                        lvl_i = 2 * n - (inner_n - 1);
                        dx = longint'(si) - (x_outer ? lvl_o : lvl_i) * d;
                        dy = longint'(sq) - (x_outer ? lvl_i : lvl_o) * d;
                        pt_dist = dx * dx + dy * dy;
                        // strict compare keeps the lower index on a tie
                        if (idx == 0 || pt_dist < best_dist)
                        begin
                            best_dist = pt_dist;
                            win_idx   = idx;
                        end
                        idx++;
                    end
                end
            end
            pick = win_idx[qhd_pkg::SYMBOL_W-1:0];
            if (model_gray)
            begin
                // each bit is the XOR of itself and every bit above it
                for (int b = 0; b < qhd_pkg::SYMBOL_W; b++)
                    res.sym[b] = ^(pick >> b);
            end
            else
            begin
                res.sym = pick;
            end
        end
        return res;
    endfunction

    // One random coordinate: near a point, on a decision boundary, raw or extreme
    function automatic logic [SAMPLE_W-1:0] rand_coord(input longint d, input int top);
        int     sel;
        int     k;
        longint v;
        sel = $urandom_range(99);
        if (d != 0 && sel < 40)
        begin
            k = 2 * int'($urandom_range(top)) - top;
            v = k * d + longint'($urandom_range(d)) - d / 2;
        end
        else if (d != 0 && sel < 60)
        begin
            k = 2 * int'($urandom_range(top + 1)) - (top + 1);
            v = k * d;
        end
        else if (sel < 85)
        begin
            v = longint'($signed(16'($urandom)));
        end
        else
        begin
            case ($urandom_range(4))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = 0;
                3:       v = -1;
                default: v = 1;
            endcase
        end
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    // Drive one sample and record its decision once the transaction completes
    task automatic send_sample(input logic [SAMPLE_W-1:0] i_raw,
                               input logic [SAMPLE_W-1:0] q_raw,
                               input bit typed, input int sym, input bit err);
        decision_t exp_dec;
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q_raw, i_raw};
        do
            @(posedge clk);
        while (!s_tready);
        if (typed)
        begin
            exp_dec.sym = sym[qhd_pkg::SYMBOL_W-1:0];
            exp_dec.err = err;
        end
        else
        begin
            exp_dec = nearest_symbol(i_raw, q_raw);
        end
        pending_decisions = {pending_decisions, exp_dec};
    endtask

    // Drain, then write both registers
    task automatic apply_config(input int order, input bit gray);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (CFG_PAUSE) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= qhd_pkg::REG_QAM_ORDER;
        cfg_data  <= order[qhd_pkg::ORDER_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        model_order = order[qhd_pkg::ORDER_W-1:0];
        @(negedge clk);
        cfg_index <= qhd_pkg::REG_GRAY_ENABLE;
        // upper bits are don't-care for this register
        cfg_data  <= {8'($urandom), gray};
        do
            @(posedge clk);
        while (!cfg_ready);
        model_gray = gray;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SRC:
            begin
                src_idle = 55; sink_stall = 0;
            end
            IDLE_SINK:
            begin
                src_idle = 0; sink_stall = 55;
            end
            IDLE_BOTH:
            begin
                src_idle = 11; sink_stall = 11;
            end
            default:
            begin
                src_idle = 0; sink_stall = 0;
            end
        endcase
    endtask

    // Random backpressure on the result side
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    // Check results in order and watch for a hang
    always @(posedge clk)
    begin
        decision_t exp_dec;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_decisions.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: symbol %0d order_error %0b",
                                 m_tdata, m_tuser[0]);
                end
                else
                begin
                    exp_dec = pending_decisions.pop_front();
                    if (m_tdata !== exp_dec.sym || m_tuser[0] !== exp_dec.err)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: symbol exp %0d got %0d, ",
                                      "order_error exp %0b got %0b"},
                                     exp_dec.sym, m_tdata, exp_dec.err, m_tuser[0]);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                hang_cycles = 0;
            else
                hang_cycles++;
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        longint          d;
        int              outer_n;
        int              inner_n;
        int              cut;
        bit              x_outer;
        longint unsigned energy;
        int              top;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = qhd_pkg::REG_QAM_ORDER;
        cfg_data    = '0;
        model_order = 9'd16;
        model_gray  = 1'b0;
        fail_count  = 0;
        hang_cycles = 0;
        src_idle    = 0;
        sink_stall  = 0;

        // order, gray, i, q, typed, symbol, order_error
        dir_rows = '{
            '{16,  0, 0,      0,      0, 0,   0},
            '{16,  0, -32768, -32768, 1, 0,   0},
            '{16,  0, 32767,  32767,  1, 15,  0},
            '{4,   0, -32768, 32767,  1, 2,   0},
            '{4,   1, 32767,  32767,  1, 2,   0},
            '{8,   0, 32767,  -32768, 1, 3,   0},
            '{8,   0, 0,      0,      0, 0,   0},
            '{32,  0, 0,      0,      0, 0,   0},
            '{32,  0, 32767,  32767,  0, 0,   0},
            '{32,  1, -32768, 0,      0, 0,   0},
            '{64,  0, -32768, -32768, 1, 0,   0},
            '{64,  1, 32767,  32767,  1, 42,  0},
            '{128, 0, 32767,  32767,  0, 0,   0},
            '{128, 0, 0,      0,      0, 0,   0},
            '{128, 1, -32768, 32767,  0, 0,   0},
            '{256, 0, 32767,  32767,  1, 255, 0},
            '{256, 0, -32768, -32768, 1, 0,   0},
            '{256, 0, 0,      0,      0, 0,   0},
            '{256, 1, 32767,  32767,  1, 170, 0},
            '{0,   0, 1234,   -1234,  1, 0,   1},
            '{257, 0, 32767,  -32768, 1, 0,   1},
            '{2,   0, -1,     -1,     1, 0,   1},
            '{511, 1, 0,      0,      1, 0,   1},
            '{16,  1, 0,      0,      0, 0,   0}
        };
        phase_order = '{4, 256, 8, 16, 32, 64, 128, 511, 64, 256, 0, 128};
        phase_gray  = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed samples; rewrite registers only when the row asks for a change
        set_idle(IDLE_NONE);
        for (int r = 0; r < DIR_N; r++)
        begin
            if (dir_rows[r].order != int'(model_order) || dir_rows[r].gray != model_gray)
                apply_config(dir_rows[r].order, dir_rows[r].gray);
            send_sample(16'(dir_rows[r].i_val), 16'(dir_rows[r].q_val),
                        dir_rows[r].typed, dir_rows[r].sym, dir_rows[r].err);
        end

        // Random samples, one register setting and idle pattern per phase
        for (int p = 0; p < PHASES; p++)
        begin
            apply_config(phase_order[p], phase_gray[p]);
            set_idle(idle_mode_t'(p % 4));
            grid_shape(model_order, outer_n, inner_n, cut, x_outer, energy);
            d   = (energy != 0) ? grid_step(energy) : 0;
            top = ((outer_n > inner_n) ? outer_n : inner_n) - 1;
            for (int n = 0; n < PHASE_LEN; n++)
                send_sample(rand_coord(d, top), rand_coord(d, top), 1'b0, 0, 1'b0);
        end

        // Drop valid, drain, then let the pipeline settle
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        fail_count += pending_decisions.size();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/qhd_pkg.sv
sv/qhd_point_rom.sv
sv/qhd_dist_search.sv
sv/qhd_ctrl.sv
sv/qam_hard_demapper.sv
tb/qam_hard_demapper_tb.sv
